// File: hw/rtl/lffa_pkg.sv
// Shared types and constants for the lifetime-aware first-fit allocator.
package lffa_pkg;

  localparam int unsigned MaxBlocks = 256;
  localparam int unsigned IdxW      = $clog2(MaxBlocks);
  localparam int unsigned CntW      = IdxW + 1;
  localparam int unsigned TimeW     = 16;
  localparam int unsigned OffW      = 40;
  localparam int unsigned FootW     = OffW + 1;
  localparam int unsigned SizeW     = 32;

  localparam logic [FootW-1:0] OffSpan = FootW'(1) << OffW;

  localparam logic [1:0] StatusPlaced = 2'd0;
  localparam logic [1:0] StatusFull   = 2'd1;
  localparam logic [1:0] StatusLimit  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_READ,
    ST_CHECK,
    ST_FINISH
  } lffa_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic rd;
    logic check;
    logic commit;
  } lffa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic last;
    logic again;
    logic out_busy;
  } lffa_stat_t;

  // One placed buffer in the table.
  typedef struct packed {
    logic [TimeW-1:0] alloc_t;
    logic [TimeW-1:0] free_t;
    logic [OffW-1:0]  low;
    logic [OffW-1:0]  high;
  } lffa_entry_t;

endpackage

// File: hw/rtl/lffa_ctrl.sv
// Sequencer for the allocator: accept, table scan passes, result commit.
module lffa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lffa_pkg::lffa_stat_t stat_i,
  output lffa_pkg::lffa_cmd_t  cmd_o
);
  import lffa_pkg::*;

  lffa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_START;
      end
      ST_START: begin
        state_d = (stat_i.full || stat_i.empty) ? ST_FINISH : ST_READ;
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        // At the end of a pass, rescan only if the candidate moved.
        if (stat_i.last && !stat_i.again) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_FINISH: begin
        if (!stat_i.out_busy) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
      end
      ST_FINISH: begin
        cmd_o.commit = !stat_i.out_busy;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// File: hw/rtl/lffa_dp.sv
// Datapath: placed-buffer table, candidate offset, limit check and result register.
module lffa_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lffa_pkg::lffa_cmd_t           cmd_i,
  output lffa_pkg::lffa_stat_t          stat_o,
  input  logic                          cfg_we_i,
  input  logic [lffa_pkg::FootW-1:0]    cfg_data_i,
  input  logic                          new_set_i,
  input  logic [lffa_pkg::SizeW-1:0]    block_size_i,
  input  logic [lffa_pkg::TimeW-1:0]    alloc_time_i,
  input  logic [lffa_pkg::TimeW-1:0]    free_time_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [lffa_pkg::OffW-1:0]     offset_low_o,
  output logic [lffa_pkg::OffW-1:0]     offset_high_o,
  output logic [lffa_pkg::FootW-1:0]    footprint_o,
  output logic [1:0]                    status_o
);
  import lffa_pkg::*;

  lffa_entry_t mem [MaxBlocks];
  lffa_entry_t rd_q;

  logic [CntW-1:0]  count_q, count_d;
  logic [FootW-1:0] peak_q, peak_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             moved_q, moved_d;
  logic             out_valid_q, out_valid_d;
  logic [FootW-1:0] limit_q;

  logic [TimeW-1:0] at_q, ft_q;
  logic [SizeW-1:0] size_q, size_eff;
  logic [FootW-1:0] cand_q, end_q;

  logic [OffW-1:0]  lo_q, hi_q;
  logic [FootW-1:0] foot_q;
  logic [1:0]       status_q;

  logic [TimeW-1:0] a_max, f_min;
  logic             clash, overlap, hit;
  logic             full, over_limit, place_ok;
  logic [FootW-1:0] new_foot;

  assign size_eff = (block_size_i == '0) ? SizeW'(1) : block_size_i;

  // Compare the candidate range against the entry read in the previous cycle.
  always_comb begin
    a_max   = (at_q > rd_q.alloc_t) ? at_q : rd_q.alloc_t;
    f_min   = (ft_q < rd_q.free_t) ? ft_q : rd_q.free_t;
    clash   = a_max < f_min;
    overlap = (cand_q <= {1'b0, rd_q.high}) && (end_q >= {1'b0, rd_q.low});
    hit     = clash && overlap;
  end

  assign full       = count_q >= CntW'(MaxBlocks);
  assign over_limit = end_q >= limit_q;
  assign place_ok   = !full && !over_limit;
  assign new_foot   = end_q + FootW'(1);

  assign stat_o.full     = full;
  assign stat_o.empty    = count_q == '0;
  assign stat_o.last     = {1'b0, idx_q} == (count_q - CntW'(1));
  assign stat_o.again    = moved_q || hit;
  assign stat_o.out_busy = out_valid_q && out_stall_i;

  always_comb begin
    count_d     = count_q;
    peak_d      = peak_q;
    idx_d       = idx_q;
    moved_d     = moved_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_i.load) begin
      idx_d   = '0;
      moved_d = 1'b0;
      if (new_set_i) begin
        count_d = '0;
        peak_d  = '0;
      end
    end
    if (cmd_i.check) begin
      if (stat_o.last) begin
        idx_d   = '0;
        moved_d = 1'b0;
      end else begin
        idx_d   = idx_q + IdxW'(1);
        moved_d = moved_q || hit;
      end
    end
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
      if (place_ok) begin
        count_d = count_q + CntW'(1);
        if (new_foot > peak_q) peak_d = new_foot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      peak_q      <= '0;
      idx_q       <= '0;
      moved_q     <= 1'b0;
      out_valid_q <= 1'b0;
      limit_q     <= OffSpan;
    end else begin
      count_q     <= count_d;
      peak_q      <= peak_d;
      idx_q       <= idx_d;
      moved_q     <= moved_d;
      out_valid_q <= out_valid_d;
      // Clamp the limit to the offset space once, at write time.
      if (cfg_we_i) limit_q <= (cfg_data_i > OffSpan) ? OffSpan : cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      at_q   <= alloc_time_i;
      ft_q   <= free_time_i;
      size_q <= size_eff;
      cand_q <= '0;
      end_q  <= FootW'(size_eff - SizeW'(1));
    end else if (cmd_i.check && hit) begin
      // Advance past the conflicting entry.
      cand_q <= {1'b0, rd_q.high} + FootW'(1);
      end_q  <= {1'b0, rd_q.high} + FootW'(size_q);
    end
    if (cmd_i.commit) begin
      lo_q     <= place_ok ? cand_q[OffW-1:0] : '0;
      hi_q     <= place_ok ? end_q[OffW-1:0] : '0;
      foot_q   <= peak_d;
      status_q <= full ? StatusFull : (over_limit ? StatusLimit : StatusPlaced);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && place_ok) begin
      mem[count_q[IdxW-1:0]] <= '{alloc_t: at_q, free_t: ft_q,
                                  low: cand_q[OffW-1:0], high: end_q[OffW-1:0]};
    end
    if (cmd_i.rd) rd_q <= mem[idx_q];
  end

  assign out_valid_o   = out_valid_q;
  assign offset_low_o  = lo_q;
  assign offset_high_o = hi_q;
  assign footprint_o   = foot_q;
  assign status_o      = status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxBlocks))
    else $error("entry count past table depth");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd |-> ({1'b0, idx_q} < count_q))
    else $error("table read beyond stored entries");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while stalled");

  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.commit))
    else $error("result raised without a commit");

endmodule

// File: hw/rtl/lifetime_first_fit_allocator_unit.sv
// Top level of the lifetime-aware first-fit offset allocator.
// Each accepted transaction places one buffer at the lowest offset that overlaps no stored
// buffer live at the same time, and returns one result transaction. An item is accepted,
// the table is checked for full or empty, scan passes read and check each stored entry in
// turn, and the result is committed. The table is rescanned while the candidate offset
// keeps moving, so a placement takes between 1 and count+1 passes. An empty or full table
// needs no scan. The table memory is read one entry at a time, each read followed by its
// check. The commit also waits while the output register holds a result that is stalled.
// A table full or a limit overrun is reported in status and the buffer is not stored. The
// input side is ready again as soon as the result sits in the output register.
module lifetime_first_fit_allocator_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lffa_pkg::FootW-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        new_set_i,
  input  logic [lffa_pkg::SizeW-1:0]  block_size_i,
  input  logic [lffa_pkg::TimeW-1:0]  alloc_time_i,
  input  logic [lffa_pkg::TimeW-1:0]  free_time_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lffa_pkg::OffW-1:0]   offset_low_o,
  output logic [lffa_pkg::OffW-1:0]   offset_high_o,
  output logic [lffa_pkg::FootW-1:0]  footprint_o,
  output logic [1:0]                  status_o
);
  import lffa_pkg::*;

  lffa_cmd_t  cmd;
  lffa_stat_t stat;

  lffa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lffa_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .new_set_i     (new_set_i),
    .block_size_i  (block_size_i),
    .alloc_time_i  (alloc_time_i),
    .free_time_i   (free_time_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .offset_low_o  (offset_low_o),
    .offset_high_o (offset_high_o),
    .footprint_o   (footprint_o),
    .status_o      (status_o)
  );

endmodule
